>>> design/box_ds_pkg.sv
// ----------------------------------------------------------------------------
// box_ds_pkg
// Shared types, constants and lane helpers of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package box_ds_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int LANE_W        = 9;
    localparam int PAIR_W        = 4 * LANE_W;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int SRC_W_W       = 13;
    localparam int SRC_H_W       = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_SRC_WIDTH    = 2'd1,
        CFG_SRC_HEIGHT   = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        FMT_ARGB8888 = 1'b0,
        FMT_RGB565   = 1'b1
    } t_pixel_format;

    typedef logic [PAIR_W-1:0] t_lanes;

    typedef struct packed {
        logic [31:0] in_pixel;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic        frame_last;
    } t_out_item;

    // Unpack one pixel into four 9-bit channel lanes: a,r,g,b from high to low.
    function automatic t_lanes to_lanes(input t_pixel_format fmt, input logic [31:0] px);
        t_lanes l;
        l = '0;
        if (fmt == FMT_RGB565) begin
            l[3*LANE_W +: LANE_W] = '0;
            l[2*LANE_W +: LANE_W] = {4'd0, px[15:11]};
            l[1*LANE_W +: LANE_W] = {3'd0, px[10:5]};
            l[0*LANE_W +: LANE_W] = {4'd0, px[4:0]};
        end else begin
            l[3*LANE_W +: LANE_W] = {1'b0, px[31:24]};
            l[2*LANE_W +: LANE_W] = {1'b0, px[23:16]};
            l[1*LANE_W +: LANE_W] = {1'b0, px[15:8]};
            l[0*LANE_W +: LANE_W] = {1'b0, px[7:0]};
        end
        return l;
    endfunction

    // Lane-wise sum of two pair sums, truncated to one quarter, packed back.
    function automatic logic [31:0] finish(input t_pixel_format fmt, input t_lanes top,
                                           input t_lanes bot);
        logic [LANE_W:0] s;
        logic [7:0]      ch [4];
        logic [31:0]     px;
        for (int i = 0; i < 4; i++) begin
            s     = {1'b0, top[i*LANE_W +: LANE_W]} + {1'b0, bot[i*LANE_W +: LANE_W]};
            ch[i] = s[LANE_W:2];
        end
        if (fmt == FMT_RGB565) begin
            px = {16'd0, ch[2][4:0], ch[1][5:0], ch[0][4:0]};
        end else begin
            px = {ch[3], ch[2], ch[1], ch[0]};
        end
        return px;
    endfunction

endpackage

`default_nettype wire

>>> design/box_ds_stream_if.sv
// ----------------------------------------------------------------------------
// box_ds_stream_if
// Valid/ready stream channel carrying one payload item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface box_ds_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/box_downsample_2x2_top.sv
// An accepted pixel that completes a block passes through stage 1, then the result register.
// Throughput: one pixel per cycle unless stalled; line store read or written once per pair.
// Stalls on the result side hold the pipeline; a new pixel still enters while the
// result register is emptied in the same cycle.
// Reset zeroes counts, held pixel, valid flags and resets config; line store is not cleared.
// ----------------------------------------------------------------------------
// box_downsample_2x2_top
// 2x2 box-filter downsampler for a raster ARGB8888 / RGB565 pixel stream.
// ----------------------------------------------------------------------------
`default_nettype none

module box_downsample_2x2_top
    import box_ds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    box_ds_stream_if.sink          i_src,
    box_ds_stream_if.source        o_res
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCW        = (CW + 1 > SRC_W_W + 1) ? CW + 1 : SRC_W_W + 1;

    // configuration
    t_pixel_format        r_fmt;
    logic [SRC_W_W-1:0]   r_src_w;
    logic [SRC_H_W-1:0]   r_src_h;

    // position and held left pixel
    logic [CW-1:0]        r_col;
    logic [SRC_H_W-1:0]   r_row;
    logic [31:0]          r_held;

    // line store
    t_lanes               r_line [LINE_DEPTH];
    t_lanes               r_rd;

    // stage 1
    logic                 r_s1_valid;
    logic                 r_s1_odd;
    logic                 r_s1_last;
    t_lanes               r_s1_pair;

    // result register
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [WCW-1:0]       w_lim;
    logic [WCW-1:0]       w_m1;
    logic [SRC_H_W-1:0]   h_m1;
    logic                 last_col;
    logic                 last_row;
    logic                 pair_done;
    logic                 row_odd;
    logic                 emit;
    logic                 accept;
    logic                 out_free;
    logic                 s1_move;
    logic [AW-1:0]        idx;
    t_lanes               pair;
    logic [31:0]          px;

    // Effective size: zero acts as one, wider than the store clamps to the store.
    always_comb begin
        if (r_src_w == '0) begin
            w_lim = WCW'(1);
        end else if (WCW'(r_src_w) > WCW'(MAX_WIDTH)) begin
            w_lim = WCW'(MAX_WIDTH);
        end else begin
            w_lim = WCW'(r_src_w);
        end
        w_m1 = w_lim - WCW'(1);
        h_m1 = (r_src_h == '0) ? '0 : r_src_h - SRC_H_W'(1);
    end

    assign px       = i_src.payload.in_pixel;
    assign last_col = WCW'(r_col) >= w_m1;
    assign last_row = r_row >= h_m1;
    assign row_odd  = r_row[0];
    assign idx      = AW'(r_col >> 1);

    always_comb begin
        if (r_col[0]) begin
            pair      = to_lanes(r_fmt, r_held) + to_lanes(r_fmt, px);
            pair_done = 1'b1;
        end else if (last_col) begin
            pair      = to_lanes(r_fmt, px) + to_lanes(r_fmt, px);
            pair_done = 1'b1;
        end else begin
            pair      = to_lanes(r_fmt, px);
            pair_done = 1'b0;
        end
    end

    assign emit     = pair_done && (row_odd || last_row);
    assign out_free = !r_out_valid || o_res.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign i_src.ready = !r_s1_valid || out_free;
    assign accept   = i_src.valid && i_src.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_ARGB8888;
            r_src_w <= SRC_W_W'(1);
            r_src_h <= SRC_H_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PIXEL_FORMAT: r_fmt   <= t_pixel_format'(i_cfg_data[0]);
                CFG_SRC_WIDTH:    r_src_w <= i_cfg_data[SRC_W_W-1:0];
                CFG_SRC_HEIGHT:   r_src_h <= i_cfg_data[SRC_H_W-1:0];
                default:          ;
            endcase
        end
    end

    // position counters and held pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (accept) begin
            if (!r_col[0] && !last_col) begin
                r_held <= px;
            end
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + SRC_H_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Even rows write pair sums; odd rows read the sum above. A row apart, or
    // at least one beat apart, so the read always sees the earlier write.
    always_ff @(posedge i_clk) begin
        if (accept && pair_done && !row_odd) begin
            r_line[idx] <= pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && pair_done && row_odd) begin
            r_rd <= r_line[idx];
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= emit;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1_pair <= pair;
            r_s1_odd  <= row_odd;
            r_s1_last <= row_odd ? (last_col && last_row) : last_col;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out.out_pixel  <= finish(r_fmt, r_s1_odd ? r_rd : r_s1_pair, r_s1_pair);
            r_out.frame_last <= r_s1_last;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2 box downsampler. A directed table covers
// reset defaults, zero sizes, both pixel formats, odd sizes and truncation.
// Random frames then vary format and size, and some have their format, width or
// height rewritten midway. The table or an in-bench model predicts each beat.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import box_ds_pkg::*;

    localparam int LINE_DEPTH  = (MAX_WIDTH_DEF + 1) / 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 750;

    typedef enum logic {
        ROW_PIX = 1'b0,
        ROW_CFG = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    reg_sel;
        logic [31:0] value;
        logic        typed;
        t_out_item   typed_res;
    } t_dir_row;

    localparam t_out_item NO_RES = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    box_ds_stream_if #(.t_payload(t_in_item))  src_if ();
    box_ds_stream_if #(.t_payload(t_out_item)) res_if ();

    box_downsample_2x2_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_src      (src_if),
        .o_res      (res_if)
    );

    // Model state: register copies, line store of pair sums, position.
    t_pixel_format fmt_q    = FMT_ARGB8888;
    logic [12:0]   width_q  = 13'd1;
    logic [15:0]   height_q = 16'd1;
    logic [35:0]   line_sums [LINE_DEPTH];
    logic [31:0]   held_q   = '0;
    logic [11:0]   col_q    = '0;
    logic [15:0]   row_q    = '0;

    t_out_item pending_averages [$];
    bit        failed    = 1'b0;
    bit        src_gaps  = 1'b1;
    bit        sink_gaps = 1'b1;
    int        beats_sent = 0;

    t_dir_row directed_rows [0:31] = '{
        '{ROW_PIX, CFG_UNUSED,       32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
        '{ROW_PIX, CFG_UNUSED,       32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
        '{ROW_PIX, CFG_UNUSED,       32'h80FF_017F, 1'b1, '{32'h80FF_017F, 1'b1}},
        // zero width and height act as one
        '{ROW_CFG, CFG_SRC_WIDTH,    32'h0000_0000, 1'b0, NO_RES},
        '{ROW_CFG, CFG_SRC_HEIGHT,   32'h0000_0000, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h1234_5678, 1'b1, '{32'h1234_5678, 1'b1}},
        // RGB565: upper half ignored on input, zero on output
        '{ROW_CFG, CFG_PIXEL_FORMAT, 32'h0000_0001, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'hFFFF_FFFF, 1'b1, '{32'h0000_FFFF, 1'b1}},
        '{ROW_PIX, CFG_UNUSED,       32'hA5A5_F81F, 1'b1, '{32'h0000_F81F, 1'b1}},
        // odd width and height: edge pixels repeat
        '{ROW_CFG, CFG_SRC_WIDTH,    32'h0000_0003, 1'b0, NO_RES},
        '{ROW_CFG, CFG_SRC_HEIGHT,   32'h0000_0003, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h0000_0000, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h5A5A_F800, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h0000_07E0, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'hFFFF_001F, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h0000_FFFF, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h0F0F_1234, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'hF0F0_8421, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h0000_FFFF, 1'b0, NO_RES},
        // 2x2 ARGB: truncation, then full scale
        '{ROW_CFG, CFG_PIXEL_FORMAT, 32'h0000_0000, 1'b0, NO_RES},
        '{ROW_CFG, CFG_SRC_WIDTH,    32'h0000_0002, 1'b0, NO_RES},
        '{ROW_CFG, CFG_SRC_HEIGHT,   32'h0000_0002, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h0000_0000, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h0000_0001, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h0000_0001, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b1}},
        '{ROW_PIX, CFG_UNUSED,       32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_PIX, CFG_UNUSED,       32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
        '{ROW_CFG, CFG_UNUSED,       32'h0000_5A5A, 1'b0, NO_RES}
    };

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Split a pixel into four 9-bit channel lanes, a,r,g,b from high to low.
    function automatic logic [35:0] split_lanes(input logic [31:0] px);
        if (fmt_q == FMT_RGB565)
            return {9'd0, 4'd0, px[15:11], 3'd0, px[10:5], 4'd0, px[4:0]};
        return {1'b0, px[31:24], 1'b0, px[23:16], 1'b0, px[15:8], 1'b0, px[7:0]};
    endfunction

    function automatic logic [31:0] quarter_pack(input logic [35:0] top,
                                                 input logic [35:0] bot);
        logic [9:0] s;
        logic [7:0] ch [4];
        for (int i = 0; i < 4; i++) begin
            s     = {1'b0, top[i*9 +: 9]} + {1'b0, bot[i*9 +: 9]};
            ch[i] = s[9:2];
        end
        if (fmt_q == FMT_RGB565)
            return {16'd0, ch[2][4:0], ch[1][5:0], ch[0][4:0]};
        return {ch[3], ch[2], ch[1], ch[0]};
    endfunction

    // Advance the model by one source pixel; returns 1 when a block completes.
    function automatic bit box_average_step(input logic [31:0] px, output t_out_item res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        bit          last_c;
        bit          last_r;
        bit          have_pair;
        bit          emit;
        logic [35:0] pair;
        int          idx;
        w = width_q;
        h = height_q;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (h == 0) h = 1;
        c = col_q;
        r = row_q;
        last_c = (c >= w - 1);
        last_r = (r >= h - 1);
        idx = (c >> 1) % LINE_DEPTH;
        emit = 1'b0;
        have_pair = 1'b1;
        pair = '0;
        res = '0;
        if (c[0]) begin
            pair = split_lanes(held_q) + split_lanes(px);
        end else if (last_c) begin
            pair = split_lanes(px) + split_lanes(px);
        end else begin
            held_q = px;
            have_pair = 1'b0;
        end
        if (have_pair) begin
            if (!r[0]) begin
                line_sums[idx] = pair;
                if (last_r) begin
                    res.out_pixel  = quarter_pack(pair, pair);
                    res.frame_last = last_c;
                    emit = 1'b1;
                end
            end else begin
                res.out_pixel  = quarter_pack(line_sums[idx], pair);
                res.frame_last = last_c && last_r;
                emit = 1'b1;
            end
        end
        if (last_c) begin
            col_q = '0;
            row_q = last_r ? 16'd0 : 16'(r + 1);
        end else begin
            col_q = 12'(c + 1);
        end
        return emit;
    endfunction

    // Present one pixel, hold it until accepted, then update the model.
    task automatic feed_pixel(input logic [31:0] px, output bit emit, output t_out_item res);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            src_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        src_if.valid   <= 1'b1;
        src_if.payload <= px;
        do @(posedge clk); while (!src_if.ready);
        beats_sent++;
        emit = box_average_step(px, res);
    endtask

    // Drain the block before touching a register.
    task automatic settle();
        src_if.valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx sel, input logic [15:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= sel;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (sel)
            CFG_PIXEL_FORMAT: fmt_q    = t_pixel_format'(data[0]);
            CFG_SRC_WIDTH:    width_q  = data[12:0];
            CFG_SRC_HEIGHT:   height_q = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_pixel();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Stream pixels until the frame wraps; optionally rewrite a register midway.
    task automatic run_frame(input int change_at, input t_cfg_idx change_reg,
                             input logic [15:0] change_val);
        int        sent;
        bit        emit;
        t_out_item res;
        sent = 0;
        do begin
            if (sent == change_at) begin
                settle();
                write_reg(change_reg, change_val);
            end
            feed_pixel(pick_pixel(), emit, res);
            if (emit) pending_averages.push_back(res);
            sent++;
        end while (!(col_q == 0 && row_q == 0));
    endtask

    // Result sink: random backpressure and in-order compare.
    initial begin
        int        stall_left;
        t_out_item head;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_if.valid && res_if.ready) begin
                if (pending_averages.size() == 0) begin
                    $error("result beat with nothing pending: out_pixel %h frame_last %b",
                           res_if.payload.out_pixel, res_if.payload.frame_last);
                    failed = 1'b1;
                end else begin
                    head = pending_averages.pop_front();
                    if (res_if.payload.out_pixel !== head.out_pixel) begin
                        $error("out_pixel: expected %h, actual %h",
                               head.out_pixel, res_if.payload.out_pixel);
                        failed = 1'b1;
                    end
                    if (res_if.payload.frame_last !== head.frame_last) begin
                        $error("frame_last: expected %b, actual %b",
                               head.frame_last, res_if.payload.frame_last);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        bit          emit;
        t_out_item   res;
        int          base;
        int          w;
        int          h;
        int          change_at;
        t_cfg_idx    change_reg;
        logic [15:0] change_val;
        logic [15:0] noise;
        logic        fmt_bit;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_PIXEL_FORMAT;
        cfg_data       <= '0;
        src_if.valid   <= 1'b0;
        src_if.payload <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(directed_rows); i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].value[15:0]);
            end else begin
                feed_pixel(directed_rows[i].value, emit, res);
                if (directed_rows[i].typed)
                    pending_averages.push_back(directed_rows[i].typed_res);
                else if (emit)
                    pending_averages.push_back(res);
            end
        end

        // Over-wide line: 8191 after masking clamps to the maximum width;
        // a zero width midway ends the line at the current pixel.
        settle();
        write_reg(CFG_PIXEL_FORMAT, 16'($urandom_range(0, 1)));
        write_reg(CFG_SRC_WIDTH, 16'hFFFF);
        write_reg(CFG_SRC_HEIGHT, 16'd1);
        run_frame(300, CFG_SRC_WIDTH, 16'd0);

        // Tallest frame, cut short by shrinking the height midway.
        settle();
        write_reg(CFG_SRC_WIDTH, 16'd3);
        write_reg(CFG_SRC_HEIGHT, 16'hFFFF);
        run_frame(37, CFG_SRC_HEIGHT, 16'd4);

        base = beats_sent;
        while (beats_sent - base < RANDOM_BEATS) begin
            case ($urandom_range(0, 19))
                0: begin
                    w = $urandom_range(41, 200);
                    h = $urandom_range(0, 3);
                end
                1, 2, 3, 4, 5: begin
                    w = $urandom_range(9, 40);
                    h = $urandom_range(1, 6);
                end
                default: begin
                    w = $urandom_range(0, 8);
                    h = $urandom_range(0, 12);
                end
            endcase
            fmt_bit = $urandom_range(0, 1);
            settle();
            // Last stretch runs without idling on either side.
            if (beats_sent - base > RANDOM_BEATS - 100) begin
                src_gaps  = 1'b0;
                sink_gaps = 1'b0;
            end else begin
                src_gaps  = ($urandom_range(0, 3) != 0);
                sink_gaps = ($urandom_range(0, 3) != 0);
            end
            noise = $urandom;
            write_reg(CFG_PIXEL_FORMAT, {noise[15:1], fmt_bit});
            noise = $urandom;
            write_reg(CFG_SRC_WIDTH, {noise[15:13], 13'(w)});
            write_reg(CFG_SRC_HEIGHT, 16'(h));

            change_at  = -1;
            change_reg = CFG_UNUSED;
            change_val = '0;
            if ($urandom_range(0, 4) == 0) begin
                change_at = $urandom_range(0, (w == 0 ? 1 : w) * (h == 0 ? 1 : h) - 1);
                noise = $urandom;
                case ($urandom_range(0, 2))
                    0: begin
                        change_reg = CFG_PIXEL_FORMAT;
                        change_val = {noise[15:1], ~fmt_bit};
                    end
                    1: begin
                        // shrink only: a wider line would read unwritten sums
                        change_reg = CFG_SRC_WIDTH;
                        change_val = 16'($urandom_range(0, w));
                    end
                    default: begin
                        change_reg = CFG_SRC_HEIGHT;
                        change_val = 16'($urandom_range(0, h + 3));
                    end
                endcase
            end
            run_frame(change_at, change_reg, change_val);
        end

        src_if.valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
